/* hw/rtl/pair_test_dedup_table_defines.svh */
// Assertion macros used by the checker of the pair test de-duplication table.
`ifndef PAIR_TEST_DEDUP_TABLE_DEFINES_SVH
`define PAIR_TEST_DEDUP_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PDT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pair table check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define PDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pair table check failed");

`endif

/* hw/rtl/pdt_pkg.sv */
// Shared types and constants of the pair test de-duplication table.
`default_nettype none

package pdt_pkg;

  localparam int MAX_OBJECTS_DEF = 64;
  localparam int STAMP_BITS_DEF  = 8;
  localparam int CNT_W           = 7;
  localparam int OBJ_W           = 6;
  localparam int OP_W            = 2;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 8;

  localparam logic [CNT_W-1:0] OBJ_COUNT_RST = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_TEST    = 2'd0,
    OP_FRAME   = 2'd1,
    OP_IGNORE  = 2'd2,
    OP_REBUILD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAME  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic locate;
    logic fire;
    logic sweep_start;
    logic sweep_wr;
    logic sweep_fill;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic wrap;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/pair_test_dedup_table.sv */
// Top level of the pair test de-duplication table.
// Each transaction is captured at its accepting edge and its result is registered at the
// output after the pair index multiply, the table read and the compare and write-back; no
// new transaction is taken until the last one is through, and a stalled output holds
// the block in its final step. After reset, after a rebuild and after a new frame that wraps
// the frame code to one, the stamp table is swept one entry per cycle over all
// MAX_OBJECTS*(MAX_OBJECTS-1)/2 entries (2016 at the default size), during which no
// transaction is accepted; the object count register may be written only while no
// transaction is in flight.
`default_nettype none

module pair_test_dedup_table
  import pdt_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CNT_W-1:0]      cfg_wr_data,   // object_count
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,      // first_index, second_index
  input  wire logic [OP_W-1:0]       in_tuser,      // op
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata      // skip, status
);

  cmd_t    cmd;
  stat_t   stat;
  logic    skip;
  status_t status;

  pdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  pdt_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (op_t'(in_tuser)),
    .in_first    (in_tdata[OBJ_W-1:0]),
    .in_second   (in_tdata[2*OBJ_W-1:OBJ_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_skip    (skip),
    .out_status  (status)
  );

  assign out_tdata = {(OUT_DATA_W - 3)'(0), status, skip};

endmodule

`default_nettype wire

/* hw/rtl/pdt_ctrl.sv */
// Controller state machine of the pair test de-duplication table.
`default_nettype none

module pdt_ctrl
  import pdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOCATE,
    S_READ,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   fill_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   fire;

  always_comb begin
    cmd         = '0;
    fire        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_tvalid;
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
      end
      S_READ: begin
      end
      S_FINISH: begin
        fire            = !out_valid_r || out_tready;
        cmd.fire        = fire;
        cmd.sweep_start = fire;
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
      end
      default: begin
      end
    endcase
    cmd.sweep_fill = fill_r;
    out_valid_nxt  = (out_valid_r && !out_tready) || fire;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      fill_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_LOCATE;
          end
        end
        S_LOCATE: begin
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (fire) begin
            if (stat.op == OP_REBUILD) begin
              fill_r  <= 1'b1;
              state_r <= S_SWEEP;
            end else if (stat.op == OP_FRAME && stat.wrap) begin
              fill_r  <= 1'b0;
              state_r <= S_SWEEP;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_SWEEP: begin
          if (stat.sweep_last) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pdt_datapath.sv */
// Datapath of the pair test de-duplication table: index unit, stamp tables and result register.
`default_nettype none

module pdt_datapath
  import pdt_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire op_t              in_op,
  input  wire logic [OBJ_W-1:0] in_first,
  input  wire logic [OBJ_W-1:0] in_second,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  output logic                  out_skip,
  output status_t               out_status
);

  localparam int DEPTH  = MAX_OBJECTS * (MAX_OBJECTS - 1) / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TERM_W = CNT_W + 1;
  localparam int PROD_W = OBJ_W + TERM_W;

  logic [CNT_W-1:0]      obj_count_r;
  op_t                   op_r;
  logic [OBJ_W-1:0]      first_r;
  logic [OBJ_W-1:0]      second_r;
  status_t               status_r;
  logic [ADDR_W-1:0]     idx_r;
  logic [STAMP_BITS-1:0] frame_code_r;
  logic [ADDR_W-1:0]     sweep_r;
  logic [STAMP_BITS-1:0] stamp_q_r;
  logic                  mc_q_r;
  logic                  skip_out_r;
  status_t               status_out_r;

  logic [STAMP_BITS-1:0] stamp_mem [DEPTH];
  logic                  mc_mem [DEPTH];

  logic [CNT_W-1:0]      n_eff;
  logic [OBJ_W-1:0]      hi;
  logic [OBJ_W-1:0]      lo;
  logic [TERM_W-1:0]     term;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     idx_sum;
  status_t               status_nxt;
  logic                  skip_nxt;
  logic                  stamp_upd;
  logic                  mc_clr;
  logic                  stamp_we;
  logic                  mc_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [STAMP_BITS-1:0] stamp_wd;
  logic                  mc_wd;

  // The pair index is folded into one product: lo*(2N-lo-1) is always even.
  always_comb begin
    n_eff = obj_count_r;
    if (32'(obj_count_r) > MAX_OBJECTS) begin
      n_eff = CNT_W'(MAX_OBJECTS);
    end
    hi      = (first_r > second_r) ? first_r : second_r;
    lo      = (first_r > second_r) ? second_r : first_r;
    term    = {n_eff, 1'b0} - TERM_W'(lo) - TERM_W'(1);
    prod    = PROD_W'(lo) * PROD_W'(term);
    idx_sum = (prod >> 1) + PROD_W'(hi) - PROD_W'(lo) - PROD_W'(1);
    status_nxt = ST_OK;
    if (op_r == OP_TEST || op_r == OP_IGNORE) begin
      if (first_r == second_r) begin
        status_nxt = ST_SAME;
      end else if ({1'b0, first_r} >= n_eff || {1'b0, second_r} >= n_eff) begin
        status_nxt = ST_RANGE;
      end
    end
  end

  always_comb begin
    skip_nxt  = 1'b0;
    stamp_upd = 1'b0;
    mc_clr    = 1'b0;
    if (status_r != ST_OK) begin
      skip_nxt = 1'b1;
    end else begin
      case (op_r) inside
        OP_TEST: begin
          if (!mc_q_r) begin
            skip_nxt = 1'b1;
          end else begin
            skip_nxt  = (stamp_q_r == frame_code_r);
            stamp_upd = 1'b1;
          end
        end
        OP_IGNORE: begin
          mc_clr = 1'b1;
        end
        OP_FRAME, OP_REBUILD: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign stamp_we = cmd.sweep_wr || (cmd.fire && stamp_upd);
  assign mc_we    = (cmd.sweep_wr && cmd.sweep_fill) || (cmd.fire && mc_clr);
  assign wr_addr  = cmd.sweep_wr ? sweep_r : idx_r;
  assign stamp_wd = (cmd.sweep_wr && !cmd.sweep_fill) ? '0 : frame_code_r;
  assign mc_wd    = cmd.sweep_wr;

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[wr_addr] <= stamp_wd;
    end
    if (mc_we) begin
      mc_mem[wr_addr] <= mc_wd;
    end
    stamp_q_r <= stamp_mem[idx_r];
    mc_q_r    <= mc_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      first_r  <= in_first;
      second_r <= in_second;
    end
    if (cmd.locate) begin
      status_r <= status_nxt;
      idx_r    <= ADDR_W'(idx_sum);
    end
    if (cmd.fire) begin
      skip_out_r   <= skip_nxt;
      status_out_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_count_r  <= OBJ_COUNT_RST;
      frame_code_r <= STAMP_BITS'(1);
      sweep_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        obj_count_r <= cfg_wr_data;
      end
      if (cmd.fire && op_r == OP_FRAME) begin
        frame_code_r <= frame_code_r + STAMP_BITS'(1);
      end
      if (cmd.sweep_start) begin
        sweep_r <= '0;
      end else if (cmd.sweep_wr) begin
        sweep_r <= sweep_r + ADDR_W'(1);
      end
    end
  end

  assign stat.op         = op_r;
  assign stat.wrap       = (frame_code_r == '0);
  assign stat.sweep_last = (sweep_r == ADDR_W'(DEPTH - 1));
  assign out_skip        = skip_out_r;
  assign out_status      = status_out_r;

endmodule

`default_nettype wire

/* hw/rtl/pdt_checker.sv */
// Port-level checker of the pair test de-duplication table and its bind.
`default_nettype none
`include "pair_test_dedup_table_defines.svh"

module pdt_checker
  import pdt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  `PDT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `PDT_ASSERT_SAME(a_status_code, out_tvalid, out_tdata[2:1] <= ST_RANGE)
  `PDT_ASSERT_SAME(a_error_skips, out_tvalid && out_tdata[2:1] != ST_OK, out_tdata[0])
  `PDT_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

endmodule

bind pair_test_dedup_table pdt_checker u_pdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/pair_dedup_monitor.sv */
// Monitor that predicts and checks the results of the pair test de-duplication table.
module pair_dedup_monitor
  import pdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CNT_W-1:0]      cfg_wr_data,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [OP_W-1:0]       in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  output int                         mismatches,
  output int                         awaited
);

  localparam int PAIRS = MAX_OBJECTS_DEF * (MAX_OBJECTS_DEF - 1) / 2;

  typedef struct packed {
    logic    skip;
    status_t status;
  } verdict_t;

  logic [STAMP_BITS_DEF-1:0] stamp_mem [PAIRS];
  bit                        collide_mem [PAIRS];
  logic [STAMP_BITS_DEF-1:0] code;
  logic [CNT_W-1:0]          obj_count;
  verdict_t                  verdicts [$];

  function automatic void fill_stamps(logic [STAMP_BITS_DEF-1:0] v);
    for (int i = 0; i < PAIRS; i++) stamp_mem[i] = v;
  endfunction

  function automatic void rebuild_pairs();
    fill_stamps(code);
    for (int i = 0; i < PAIRS; i++) collide_mem[i] = 1'b1;
  endfunction

  function automatic verdict_t apply_op(op_t op, logic [OBJ_W-1:0] a, logic [OBJ_W-1:0] b);
    verdict_t v;
    int n, hi, lo, slot;
    v.skip = 1'b0;
    v.status = ST_OK;
    n = (obj_count > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : int'(obj_count);
    case (op)
      OP_TEST, OP_IGNORE: begin
        if (a == b) v.status = ST_SAME;
        else if (int'(a) >= n || int'(b) >= n) v.status = ST_RANGE;
        if (v.status != ST_OK) begin
          v.skip = 1'b1;
        end else begin
          hi = (a > b) ? int'(a) : int'(b);
          lo = (a > b) ? int'(b) : int'(a);
          slot = hi - lo - 1 + n * lo - (lo * (lo + 1)) / 2;
          if (op == OP_IGNORE) begin
            collide_mem[slot] = 1'b0;
          end else if (!collide_mem[slot]) begin
            v.skip = 1'b1;
          end else begin
            v.skip = (stamp_mem[slot] == code);
            stamp_mem[slot] = code;
          end
        end
      end
      OP_FRAME: begin
        code = code + 1'b1;
        if (code == 1) fill_stamps('0);
      end
      default: rebuild_pairs();
    endcase
    return v;
  endfunction

  always @(posedge clk) begin : track
    verdict_t want;
    if (!rst_n) begin
      obj_count = OBJ_COUNT_RST;
      code = STAMP_BITS_DEF'(1);
      rebuild_pairs();
      verdicts.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result transaction: tdata %0h", out_tdata);
          mismatches++;
        end else begin
          want = verdicts.pop_front();
          if (out_tdata[0] !== want.skip) begin
            $error("skip: expected %0d, actual %0d", want.skip, out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[2:1] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tdata[2:1]);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) obj_count = cfg_wr_data;
      if (in_tvalid && in_tready)
        verdicts.insert(verdicts.size(),
                        apply_op(op_t'(in_tuser), in_tdata[OBJ_W-1:0],
                                 in_tdata[2*OBJ_W-1:OBJ_W]));
    end
    awaited = verdicts.size();
  end

endmodule

/* tb/tb_pair_test_dedup_table.sv */
// Top of the testbench for the pair test de-duplication table: stimulus and verdict.
module tb_pair_test_dedup_table;
  import pdt_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CNT_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    awaited;

  bit calm;
  bit hold_req;
  int n_eff;
  int frames_sent;

  pair_test_dedup_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pair_dedup_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic put_item(op_t op, logic [OBJ_W-1:0] a, logic [OBJ_W-1:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, b, a};
    if (op == OP_FRAME) frames_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_count(logic [CNT_W-1:0] v);
    in_tvalid <= 1'b0;
    wait (awaited == 0);
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_eff = (v > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : int'(v);
  endtask

  task automatic put_random(int frame_pct, int ignore_pct, int rebuild_pct);
    int roll, span;
    logic [OBJ_W-1:0] a, b;
    op_t op;
    roll = $urandom_range(0, 99);
    if (roll < frame_pct) op = OP_FRAME;
    else if (roll < frame_pct + ignore_pct) op = OP_IGNORE;
    else if (roll < frame_pct + ignore_pct + rebuild_pct) op = OP_REBUILD;
    else op = OP_TEST;
    roll = $urandom_range(0, 99);
    if (n_eff >= 2 && roll < 80) begin
      // A narrow pool of objects half the time, so that pairs repeat within a frame.
      span = ($urandom_range(0, 1) && n_eff > 6) ? 6 : n_eff;
      a = OBJ_W'($urandom_range(0, span - 1));
      b = OBJ_W'((int'(a) + int'($urandom_range(1, span - 1))) % span);
    end else if (roll < 90) begin
      a = OBJ_W'($urandom_range(0, 63));
      b = a;
    end else begin
      a = OBJ_W'($urandom_range(0, 63));
      b = OBJ_W'($urandom_range(0, 63));
    end
    put_item(op, a, b);
  endtask

  task automatic random_items(int count, int frame_pct, int ignore_pct, int rebuild_pct);
    for (int i = 0; i < count; i++) put_random(frame_pct, ignore_pct, rebuild_pct);
  endtask

  initial begin : result_sink
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_TEST;
    calm        = 1'b0;
    hold_req    = 1'b0;
    frames_sent = 0;
    n_eff       = MAX_OBJECTS_DEF;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    set_count(7'd64);

    // After reset every stamp equals the frame code, so the first test is skipped.
    put_item(OP_TEST, 6'd0, 6'd1);
    put_item(OP_FRAME, 6'd0, 6'd0);
    put_item(OP_TEST, 6'd0, 6'd1);
    put_item(OP_TEST, 6'd1, 6'd0);
    put_item(OP_TEST, 6'd63, 6'd62);
    put_item(OP_TEST, 6'd0, 6'd63);
    put_item(OP_TEST, 6'd5, 6'd5);
    put_item(OP_TEST, 6'd63, 6'd63);
    put_item(OP_IGNORE, 6'd7, 6'd7);
    put_item(OP_IGNORE, 6'd10, 6'd20);
    put_item(OP_TEST, 6'd20, 6'd10);
    put_item(OP_REBUILD, 6'd63, 6'd63);
    put_item(OP_TEST, 6'd10, 6'd20);
    put_item(OP_FRAME, 6'd63, 6'd0);
    put_item(OP_TEST, 6'd10, 6'd20);
    set_count(7'd2);
    put_item(OP_TEST, 6'd0, 6'd1);
    put_item(OP_TEST, 6'd0, 6'd2);
    put_item(OP_IGNORE, 6'd63, 6'd0);
    put_item(OP_TEST, 6'd1, 6'd1);
    put_item(OP_REBUILD, 6'd0, 6'd0);
    set_count(7'd127);
    put_item(OP_TEST, 6'd63, 6'd0);
    put_item(OP_TEST, 6'd62, 6'd63);
    set_count(7'd1);
    put_item(OP_TEST, 6'd0, 6'd1);
    put_item(OP_TEST, 6'd0, 6'd0);
    random_items(10, 10, 20, 0);

    set_count(7'd64);
    put_item(OP_REBUILD, 6'd0, 6'd0);
    random_items(50, 8, 8, 1);
    hold_req = 1'b1;
    random_items(70, 8, 8, 1);

    set_count(7'($urandom_range(3, 63)));
    put_item(OP_REBUILD, 6'd0, 6'd0);
    random_items(60, 8, 10, 1);

    set_count(7'd2);
    put_item(OP_REBUILD, 6'd0, 6'd0);
    random_items(40, 15, 15, 2);

    // Enough new frames that the frame code wraps and the stamps are cleared.
    set_count(7'd64);
    put_item(OP_REBUILD, 6'd0, 6'd0);
    while (frames_sent < 300) put_random(85, 3, 0);

    calm = 1'b1;
    random_items(50, 8, 8, 2);

    in_tvalid <= 1'b0;
    wait (awaited == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pdt_pkg.sv
hw/rtl/pdt_ctrl.sv
hw/rtl/pdt_datapath.sv
hw/rtl/pair_test_dedup_table.sv
hw/rtl/pdt_checker.sv
tb/pair_dedup_monitor.sv
tb/tb_pair_test_dedup_table.sv
